@@ hdl/tpt_state_variable_filter_unit_macros.svh @@
// Assertion macros used by the state variable filter sequencer.
`ifndef TPT_STATE_VARIABLE_FILTER_UNIT_MACROS_SVH
`define TPT_STATE_VARIABLE_FILTER_UNIT_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define TPT_SVF_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define TPT_SVF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/tpt_svf_pkg.sv @@
// Shared types, constants and table functions of the state variable filter.
`default_nettype none

package tpt_svf_pkg;

    localparam int CLIP_TABLE_BITS_DEF = 10;

    localparam int SAMPLE_W    = 24;
    localparam int CUTOFF_W    = 19;
    localparam int DAMPING_W   = 18;
    localparam int NORM_W      = 17;
    localparam int DRIVE_W     = 18;
    localparam int CFG_DATA_W  = 19;
    localparam int CFG_INDEX_W = 2;
    localparam int STATE_W     = 32;
    localparam int CLIP_W      = 23;
    localparam int SUM_W       = 47;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_CUTOFF_GAIN   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DAMPING       = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FEEDBACK_NORM = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DRIVE_GAIN    = 2'd3;

    localparam logic [CUTOFF_W-1:0]  CUTOFF_GAIN_RST   = 19'd8192;
    localparam logic [DAMPING_W-1:0] DAMPING_RST       = 18'd131072;
    localparam logic [NORM_W-1:0]    FEEDBACK_NORM_RST = 17'd52428;
    localparam logic [DRIVE_W-1:0]   DRIVE_GAIN_RST    = 18'd65536;

    localparam logic [63:0] ONE_Q31 = 64'd2147483648;

    typedef struct packed {
        logic [CUTOFF_W-1:0]  cutoff_gain;
        logic [DAMPING_W-1:0] damping;
        logic [NORM_W-1:0]    feedback_norm;
        logic [DRIVE_W-1:0]   drive_gain;
    } cfg_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_MUL_DRIVE,
        OP_CLIP_ADDR,
        OP_RD_LO,
        OP_RD_HI,
        OP_MUL_INTERP,
        OP_CLIP_DONE,
        OP_NUM,
        OP_MUL_HP,
        OP_HP,
        OP_MUL_GHP,
        OP_GHP,
        OP_BP,
        OP_MUL_GBP,
        OP_GBP,
        OP_LP
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   load;
    } dp_cmd_t;

    // e^-z in Q.31 for z in [0, 6], series plus six squarings.
    function automatic logic [63:0] exp_neg_q31(input logic [63:0] z);
        logic [63:0] w;
        logic [63:0] w2;
        logic [63:0] w3;
        logic [63:0] w4;
        logic [63:0] e;
        int          n;
        w  = z >> 6;
        w2 = (w * w) >> 31;
        w3 = (w2 * w) >> 31;
        w4 = (w3 * w) >> 31;
        e  = ONE_Q31 - w + (w2 >> 1) + w4 / 24 - w3 / 6;
        for (n = 0; n < 6; n++) begin
            e = (e * e) >> 31;
        end
        return e;
    endfunction

    // One soft clip entry: round(tanh(1.5x)/1.5 * 2^23), x = 2*idx/2^bits.
    function automatic logic [CLIP_W-1:0] clip_entry(input int idx, input int bits);
        logic [63:0] z;
        logic [63:0] t;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] dvd;
        logic [63:0] quo;
        logic [63:0] rem;
        int          b;
        z   = (64'd6 * 64'(idx)) << (31 - bits);
        t   = exp_neg_q31(z);
        num = (ONE_Q31 - t) << 24;
        den = 64'd3 * (ONE_Q31 + t);
        dvd = num + (den >> 1);
        quo = '0;
        rem = '0;
        // restoring long division, one quotient bit per pass
        for (b = 63; b >= 0; b--) begin
            rem = {rem[62:0], dvd[b]};
            quo = quo << 1;
            if (rem >= den) begin
                rem    = rem - den;
                quo[0] = 1'b1;
            end
        end
        return quo[CLIP_W-1:0];
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = 47'sd8388607;
        lo = -47'sd8388608;
        if (v > hi) begin
            return hi[SAMPLE_W-1:0];
        end else if (v < lo) begin
            return lo[SAMPLE_W-1:0];
        end
        return v[SAMPLE_W-1:0];
    endfunction

    function automatic logic signed [STATE_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = 47'sd2147483647;
        lo = -47'sd2147483648;
        if (v > hi) begin
            return hi[STATE_W-1:0];
        end else if (v < lo) begin
            return lo[STATE_W-1:0];
        end
        return v[STATE_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ hdl/tpt_svf_cfg.sv @@
// Configuration register file of the state variable filter.
`default_nettype none

module tpt_svf_cfg import tpt_svf_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cutoff_gain   <= CUTOFF_GAIN_RST;
            cfg_reg.damping       <= DAMPING_RST;
            cfg_reg.feedback_norm <= FEEDBACK_NORM_RST;
            cfg_reg.drive_gain    <= DRIVE_GAIN_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_CUTOFF_GAIN:   cfg_reg.cutoff_gain   <= cfg_wdata[CUTOFF_W-1:0];
                REG_DAMPING:       cfg_reg.damping       <= cfg_wdata[DAMPING_W-1:0];
                REG_FEEDBACK_NORM: cfg_reg.feedback_norm <= cfg_wdata[NORM_W-1:0];
                REG_DRIVE_GAIN:    cfg_reg.drive_gain    <= cfg_wdata[DRIVE_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ hdl/tpt_svf_dp.sv @@
// Datapath: shared multiplier, soft clip table and integrator update.
`default_nettype none

module tpt_svf_dp import tpt_svf_pkg::*; #(
    parameter int CLIP_TABLE_BITS = CLIP_TABLE_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  cfg_t                       cfg,
    input  dp_cmd_t                    cmd,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    output logic signed [SAMPLE_W-1:0] low_out,
    output logic signed [SAMPLE_W-1:0] band_out,
    output logic signed [SAMPLE_W-1:0] high_out
);

    localparam int CLIP_SIZE  = (1 << CLIP_TABLE_BITS) + 1;
    localparam int CLIP_SHIFT = 24 - CLIP_TABLE_BITS;
    localparam int CLIP_AW    = CLIP_TABLE_BITS + 1;
    localparam int MA_W       = 41;
    localparam int MB_W       = 20;
    localparam int PROD_W     = MA_W + MB_W;
    localparam int RND_W      = PROD_W - 16;
    localparam int NUM_W      = 36;
    localparam int HP_W       = 37;
    localparam int GHP_W      = 40;
    localparam int BP_W       = 41;
    localparam logic [24:0] CLIP_ONE = 25'd16777216;

    typedef logic [CLIP_W-1:0] clip_rom_t [CLIP_SIZE];

    function automatic clip_rom_t build_rom();
        clip_rom_t r;
        int        i;
        for (i = 0; i < CLIP_SIZE; i++) begin
            r[i] = clip_entry(i, CLIP_TABLE_BITS);
        end
        return r;
    endfunction

    localparam clip_rom_t CLIP_ROM = build_rom();

    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic [CLIP_AW-1:0]         idx_reg;
    logic [CLIP_SHIFT-1:0]      frac_reg;
    logic                       neg_reg;
    logic                       sat_reg;
    logic [CLIP_W-1:0]          rom_q_reg;
    logic [CLIP_W-1:0]          lo_reg;
    logic signed [SAMPLE_W-1:0] v_reg;
    logic signed [NUM_W-1:0]    num_reg;
    logic signed [HP_W-1:0]     hp_reg;
    logic signed [GHP_W-1:0]    ghp_reg;
    logic signed [BP_W-1:0]     bp_reg;
    logic signed [RND_W-1:0]    gbp_reg;
    logic signed [STATE_W-1:0]  fi_reg;
    logic signed [STATE_W-1:0]  si_reg;
    logic signed [SAMPLE_W-1:0] low_reg;
    logic signed [SAMPLE_W-1:0] band_reg;
    logic signed [SAMPLE_W-1:0] high_reg;

    logic signed [MA_W-1:0]   mul_a;
    logic [MB_W-2:0]          mul_b;
    logic                     mul_en;
    logic [PROD_W-1:0]        prod_mag;
    logic [RND_W-1:0]         rnd_mag;
    logic signed [RND_W-1:0]  rnd_val;
    logic [RND_W-1:0]         clip_mag;
    logic [24:0]              clip_abs;
    logic [CLIP_AW-1:0]       hi_addr;
    logic [CLIP_AW-1:0]       rom_addr;
    logic [CLIP_W-1:0]        diff;
    logic [CLIP_W-1:0]        interp;
    logic [SAMPLE_W-1:0]      clip_y;
    logic signed [SUM_W-1:0]  num_full;
    logic signed [SUM_W-1:0]  bp_full;
    logic signed [SUM_W-1:0]  fi_sum;
    logic signed [SUM_W-1:0]  lp_full;
    logic signed [SUM_W-1:0]  si_sum;

    // Round half away from zero, drop 16 fraction bits.
    assign prod_mag = prod_reg[PROD_W-1] ? (~prod_reg + 1'b1) : prod_reg;
    assign rnd_mag  = RND_W'((prod_mag + PROD_W'(32768)) >> 16);
    assign rnd_val  = prod_reg[PROD_W-1] ? signed'(~rnd_mag + 1'b1) : signed'(rnd_mag);

    // Soft clip address from the driven sample.
    assign clip_mag = rnd_val[RND_W-1] ? (~rnd_val + 1'b1) : rnd_val;
    assign clip_abs = (clip_mag > RND_W'(CLIP_ONE)) ? CLIP_ONE : clip_mag[24:0];
    assign hi_addr  = sat_reg ? idx_reg : idx_reg + 1'b1;
    assign rom_addr = (cmd.op == OP_RD_HI) ? hi_addr : idx_reg;
    assign diff     = (rom_q_reg >= lo_reg) ? rom_q_reg - lo_reg : '0;
    assign interp   = prod_reg[CLIP_SHIFT +: CLIP_W];
    assign clip_y   = sat_reg ? {1'b0, lo_reg} : {1'b0, lo_reg} + {1'b0, interp};

    assign num_full = v_reg - rnd_val - si_reg;
    assign bp_full  = ghp_reg + fi_reg;
    assign fi_sum   = ghp_reg + bp_full;
    assign lp_full  = gbp_reg + si_reg;
    assign si_sum   = gbp_reg + lp_full;

    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        case (cmd.op)
            OP_MUL_DRIVE: begin
                mul_a = MA_W'(sample_reg);
                mul_b = (MB_W-1)'(cfg.drive_gain);
            end
            OP_MUL_INTERP: begin
                mul_a = signed'(MA_W'(diff));
                mul_b = (MB_W-1)'(frac_reg);
            end
            OP_CLIP_DONE: begin
                mul_a = MA_W'(fi_reg);
                mul_b = (MB_W-1)'(cfg.damping);
            end
            OP_MUL_HP: begin
                mul_a = MA_W'(num_reg);
                mul_b = (MB_W-1)'(cfg.feedback_norm);
            end
            OP_MUL_GHP: begin
                mul_a = MA_W'(hp_reg);
                mul_b = cfg.cutoff_gain;
            end
            OP_MUL_GBP: begin
                mul_a = bp_reg;
                mul_b = cfg.cutoff_gain;
            end
            default: mul_en = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= mul_a * signed'({1'b0, mul_b});
        end
        if (cmd.op == OP_RD_LO || cmd.op == OP_RD_HI) begin
            rom_q_reg <= CLIP_ROM[rom_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            sample_reg <= sample_in;
        end
        case (cmd.op)
            OP_CLIP_ADDR: begin
                neg_reg  <= rnd_val[RND_W-1];
                idx_reg  <= clip_abs[24:CLIP_SHIFT];
                frac_reg <= clip_abs[CLIP_SHIFT-1:0];
                sat_reg  <= clip_abs[24];
            end
            OP_RD_HI:     lo_reg  <= rom_q_reg;
            OP_CLIP_DONE: v_reg   <= neg_reg ? signed'(~clip_y + 1'b1) : signed'(clip_y);
            OP_NUM:       num_reg <= num_full[NUM_W-1:0];
            OP_HP:        hp_reg  <= rnd_val[HP_W-1:0];
            OP_GHP:       ghp_reg <= rnd_val[GHP_W-1:0];
            OP_BP:        bp_reg  <= bp_full[BP_W-1:0];
            OP_GBP:       gbp_reg <= rnd_val;
            OP_LP: begin
                low_reg  <= sat24(lp_full);
                band_reg <= sat24(SUM_W'(bp_reg));
                high_reg <= sat24(SUM_W'(hp_reg));
            end
            default: ;
        endcase
    end

    // Integrator state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fi_reg <= '0;
            si_reg <= '0;
        end else begin
            if (cmd.op == OP_BP) begin
                fi_reg <= sat32(fi_sum);
            end
            if (cmd.op == OP_LP) begin
                si_reg <= sat32(si_sum);
            end
        end
    end

    assign low_out  = low_reg;
    assign band_out = band_reg;
    assign high_out = high_reg;

endmodule

`default_nettype wire

@@ hdl/tpt_svf_ctrl.sv @@
// Sequencer of the state variable filter: steps the datapath, owns handshakes.
`default_nettype none

`include "tpt_state_variable_filter_unit_macros.svh"

module tpt_svf_ctrl import tpt_svf_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    output logic    m_valid,
    input  logic    m_ready,
    output dp_cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_DRIVE,
        ST_CLIP_ADDR,
        ST_RD_LO,
        ST_RD_HI,
        ST_MUL_INTERP,
        ST_CLIP_DONE,
        ST_NUM,
        ST_MUL_HP,
        ST_HP,
        ST_MUL_GHP,
        ST_GHP,
        ST_BP,
        ST_MUL_GBP,
        ST_GBP,
        ST_LP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   out_free;
    logic   accept;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd.load   = accept;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            ST_IDLE:       if (accept) state_next = ST_MUL_DRIVE;
            ST_MUL_DRIVE:  begin cmd.op = OP_MUL_DRIVE;  state_next = ST_CLIP_ADDR;  end
            ST_CLIP_ADDR:  begin cmd.op = OP_CLIP_ADDR;  state_next = ST_RD_LO;      end
            ST_RD_LO:      begin cmd.op = OP_RD_LO;      state_next = ST_RD_HI;      end
            ST_RD_HI:      begin cmd.op = OP_RD_HI;      state_next = ST_MUL_INTERP; end
            ST_MUL_INTERP: begin cmd.op = OP_MUL_INTERP; state_next = ST_CLIP_DONE;  end
            ST_CLIP_DONE:  begin cmd.op = OP_CLIP_DONE;  state_next = ST_NUM;        end
            ST_NUM:        begin cmd.op = OP_NUM;        state_next = ST_MUL_HP;     end
            ST_MUL_HP:     begin cmd.op = OP_MUL_HP;     state_next = ST_HP;         end
            ST_HP:         begin cmd.op = OP_HP;         state_next = ST_MUL_GHP;    end
            ST_MUL_GHP:    begin cmd.op = OP_MUL_GHP;    state_next = ST_GHP;        end
            ST_GHP:        begin cmd.op = OP_GHP;        state_next = ST_BP;         end
            ST_BP:         begin cmd.op = OP_BP;         state_next = ST_MUL_GBP;    end
            ST_MUL_GBP:    begin cmd.op = OP_MUL_GBP;    state_next = ST_GBP;        end
            ST_GBP:        begin cmd.op = OP_GBP;        state_next = ST_LP;         end
            ST_LP: begin
                // hold until the output register is free
                if (out_free) begin
                    cmd.op     = OP_LP;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_LP && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    `TPT_SVF_ASSERT_NEXT(a_accept_starts, aclk, aresetn, s_valid && s_ready, state_reg == ST_MUL_DRIVE, "accepted beat did not start the sequence")
    `TPT_SVF_ASSERT_SAME(a_valid_from_lp, aclk, aresetn, $rose(m_valid_reg), $past(state_reg == ST_LP), "result raised outside the final step")
    `TPT_SVF_ASSERT_NEXT(a_lp_holds, aclk, aresetn, state_reg == ST_LP && m_valid_reg && !m_ready, state_reg == ST_LP, "final step advanced over a pending result")

endmodule

`default_nettype wire

@@ hdl/tpt_state_variable_filter_unit.sv @@
// Top level of the trapezoidal state variable filter with drive and soft clip.
//
// Usage:
//   Input channel s_valid / s_ready carries one signed Q1.23 sample per beat.
//   Result channel m_valid / m_ready carries the low-pass, band-pass and
//   high-pass outputs of that sample, one result beat per input beat.
//   Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect at once;
//   issue them only while the filter is idle.
//   The result is registered in the final step of the sequence; a new beat
//   is accepted only while idle. The single shared multiplier is used six
//   times per sample and the soft clip table has one read port, so the
//   sequencer steps through 15 operations after each accepted beat.
//   A finished result waits in the output register; the next sample is
//   accepted meanwhile and runs up to its final step, where it holds while
//   the receiver stalls, so no result is dropped or overwritten.
//   Reset (aresetn low, synchronous) clears both integrators, drops any
//   pending result and restores the register defaults: cutoff_gain 8192,
//   damping 131072, feedback_norm 52428, drive_gain 65536.
`default_nettype none

module tpt_state_variable_filter_unit import tpt_svf_pkg::*; #(
    parameter int CLIP_TABLE_BITS = CLIP_TABLE_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [SAMPLE_W-1:0] s_sample_in,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [SAMPLE_W-1:0] m_low_out,
    output logic signed [SAMPLE_W-1:0] m_band_out,
    output logic signed [SAMPLE_W-1:0] m_high_out,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_wdata
);

    cfg_t    cfg;
    dp_cmd_t cmd;

    // Coefficient registers loaded by software.
    tpt_svf_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Sequencer: accept a beat, step the datapath, present the result.
    tpt_svf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // Arithmetic: drive, soft clip, filter equations and integrator state.
    tpt_svf_dp #(
        .CLIP_TABLE_BITS (CLIP_TABLE_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .cmd       (cmd),
        .sample_in (s_sample_in),
        .low_out   (m_low_out),
        .band_out  (m_band_out),
        .high_out  (m_high_out)
    );

endmodule

`default_nettype wire
